// File: hw/rtl/pfc_pkg.sv
// pfc_pkg: shared types, constants and key square geometry helpers
// used by every module of the digram cipher block except pfc_ram
// no dependencies
package pfc_pkg;

    localparam int LETTER_W = 5;
    localparam int CELL_W   = 5;
    localparam int RC_W     = 3;
    localparam int CELLS    = 25;
    localparam int LETTERS  = 26;
    localparam int SIDE     = 5;

    localparam logic [LETTER_W-1:0] LETTER_I = LETTER_W'(8);
    localparam logic [LETTER_W-1:0] LETTER_J = LETTER_W'(9);
    localparam logic [LETTER_W-1:0] LETTER_Y = LETTER_W'(24);
    localparam logic [LETTER_W-1:0] LETTER_Z = LETTER_W'(25);
    localparam logic [LETTER_W-1:0] LETTER_LAST = LETTER_W'(LETTERS - 1);
    localparam logic [CELL_W-1:0]   CELLS_FULL = CELL_W'(CELLS);

    localparam logic [RC_W-1:0] SHIFT_ENC = RC_W'(1);
    localparam logic [RC_W-1:0] SHIFT_DEC = RC_W'(4);

    localparam logic [LETTERS-1:0] USED_RESET = LETTERS'(1) << LETTER_J;

    typedef enum logic [2:0] {
        REQ_CLEAR  = 3'd0,
        REQ_KEY    = 3'd1,
        REQ_FINISH = 3'd2,
        REQ_TEXT   = 3'd3,
        REQ_END    = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_CELL_A,
        ST_CELL_B,
        ST_POS,
        ST_KEY_A,
        ST_KEY_B,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
    } digram_t;

    function automatic logic [RC_W-1:0] cell_row(input logic [CELL_W-1:0] i);
        logic [RC_W-1:0] r;
        if (i < CELL_W'(5)) begin
            r = RC_W'(0);
        end else if (i < CELL_W'(10)) begin
            r = RC_W'(1);
        end else if (i < CELL_W'(15)) begin
            r = RC_W'(2);
        end else if (i < CELL_W'(20)) begin
            r = RC_W'(3);
        end else begin
            r = RC_W'(4);
        end
        return r;
    endfunction

    function automatic logic [RC_W-1:0] cell_col(input logic [CELL_W-1:0] i);
        logic [RC_W-1:0] r;
        logic [CELL_W-1:0] base;
        r    = cell_row(i);
        base = {r[RC_W-1:0], 2'b00} + CELL_W'(r);
        return RC_W'(i - base);
    endfunction

    function automatic logic [CELL_W-1:0] cell_at(input logic [RC_W-1:0] r,
                                                  input logic [RC_W-1:0] c);
        return {r, 2'b00} + CELL_W'(r) + CELL_W'(c);
    endfunction

    function automatic logic [RC_W-1:0] shift5(input logic [RC_W-1:0] v,
                                               input logic [RC_W-1:0] x);
        logic [RC_W:0] s;
        s = {1'b0, v} + {1'b0, x};
        if (s >= (RC_W+1)'(SIDE)) begin
            s = s - (RC_W+1)'(SIDE);
        end
        return s[RC_W-1:0];
    endfunction

    function automatic logic [LETTER_W-1:0] filler_for(input logic [LETTER_W-1:0] l);
        return (l != LETTER_Z) ? LETTER_Z : LETTER_Y;
    endfunction

    function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

endpackage

// File: hw/rtl/playfair_digram_cipher.sv
// playfair_digram_cipher: top level, request decode, square fill and
// digram sequencer; depends on pfc_pkg, pfc_ram, pfc_cell_map, pfc_out_buf
//
// Takes one request per cycle for clear, key letter and end of text without
// a held letter, and for a text letter that only gets held. A finish
// request, unless the square is already full, walks all 26 letters, one per
// cycle. A request that yields a digram steps through the accept, two reads
// of the letter-to-cell memory, the row and column rule, and two reads of
// the key square memory, the second overlapped with the hand-off to the
// output buffer. The buffer then sends the two letters while the next
// request is taken; while it still holds the previous digram the hand-off
// waits, and so does the input.
// Text is ignored until the square holds all 25 letters.
module playfair_digram_cipher
    import pfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wen,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] letter
    input  logic [2:0] s_tuser,   // [2:0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [4:0] out_letter
    output logic       m_tlast    // pair_last
);

    state_t              state_reg, state_next;
    logic                mode_reg;
    logic [CELL_W-1:0]   fill_reg, fill_next;
    logic [LETTER_W-1:0] held_reg, held_next;
    logic                held_valid_reg, held_valid_next;
    logic [LETTERS-1:0]  used_reg, used_next;
    logic [LETTER_W-1:0] scan_reg, scan_next;
    logic [LETTER_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [CELL_W-1:0]   i1_reg, i1_next;
    logic [LETTER_W-1:0] k0_reg, k0_next;

    logic                place_en;
    logic [LETTER_W-1:0] place_letter;
    logic [LETTER_W-1:0] lc_raddr, lc_rdata;
    logic [CELL_W-1:0]   ks_raddr, ks_rdata;
    logic                map_load;
    logic [CELL_W-1:0]   o1, o2;
    logic                ob_load, ob_busy;
    digram_t             ob_din;

    req_t                req;
    logic [LETTER_W-1:0] in_letter;
    logic                full;

    assign req       = req_t'(s_tuser);
    assign in_letter = s_tdata[LETTER_W-1:0];
    assign full      = (fill_reg == CELLS_FULL);
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        used_next       = used_reg;
        scan_next       = scan_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        i1_next         = i1_reg;
        k0_next         = k0_reg;
        place_en        = 1'b0;
        place_letter    = in_letter;
        lc_raddr        = b_reg;
        ks_raddr        = o2;
        map_load        = 1'b0;
        ob_load         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (req)
                        REQ_CLEAR: begin
                            used_next       = USED_RESET;
                            fill_next       = '0;
                            held_next       = '0;
                            held_valid_next = 1'b0;
                        end
                        REQ_KEY: begin
                            if (in_letter <= LETTER_LAST && !full
                                && !used_reg[in_letter]) begin
                                place_en = 1'b1;
                            end
                        end
                        REQ_FINISH: begin
                            if (!full) begin
                                scan_next  = '0;
                                state_next = ST_FILL;
                            end
                        end
                        REQ_TEXT: begin
                            if (full && in_letter <= LETTER_LAST) begin
                                if (!held_valid_reg) begin
                                    held_next       = in_letter;
                                    held_valid_next = 1'b1;
                                end else begin
                                    a_next     = fold_j(held_reg);
                                    state_next = ST_CELL_A;
                                    if (in_letter == held_reg) begin
                                        b_next = fold_j(filler_for(held_reg));
                                    end else begin
                                        b_next          = fold_j(in_letter);
                                        held_valid_next = 1'b0;
                                    end
                                end
                            end
                        end
                        REQ_END: begin
                            if (full && held_valid_reg) begin
                                held_valid_next = 1'b0;
                                a_next          = fold_j(held_reg);
                                b_next          = fold_j(filler_for(held_reg));
                                state_next      = ST_CELL_A;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                place_letter = scan_reg;
                if (!full && !used_reg[scan_reg]) begin
                    place_en = 1'b1;
                end
                scan_next = scan_reg + LETTER_W'(1);
                if (scan_reg == LETTER_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CELL_A: begin
                lc_raddr   = a_reg;
                state_next = ST_CELL_B;
            end
            ST_CELL_B: begin
                i1_next    = lc_rdata;
                state_next = ST_POS;
            end
            ST_POS: begin
                map_load   = 1'b1;
                state_next = ST_KEY_A;
            end
            ST_KEY_A: begin
                ks_raddr   = o1;
                state_next = ST_KEY_B;
            end
            ST_KEY_B: begin
                k0_next    = ks_rdata;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!ob_busy) begin
                    ob_load    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (place_en) begin
            used_next[place_letter] = 1'b1;
            fill_next               = fill_reg + CELL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= 1'b0;
            fill_reg       <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            used_reg       <= USED_RESET;
            scan_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            used_reg       <= used_next;
            scan_reg       <= scan_next;
            if (cfg_wen) begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        i1_reg <= i1_next;
        k0_reg <= k0_next;
    end

    // key square: cell -> letter
    pfc_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (CELLS)
    ) u_key_square (
        .aclk  (aclk),
        .we    (place_en),
        .waddr (fill_reg),
        .wdata (place_letter),
        .raddr (ks_raddr),
        .rdata (ks_rdata)
    );

    // letter -> cell
    pfc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (LETTERS)
    ) u_letter_cell (
        .aclk  (aclk),
        .we    (place_en),
        .waddr (place_letter),
        .wdata (fill_reg),
        .raddr (lc_raddr),
        .rdata (lc_rdata)
    );

    pfc_cell_map u_cell_map (
        .aclk    (aclk),
        .load    (map_load),
        .decrypt (mode_reg),
        .cell_a  (i1_reg),
        .cell_b  (lc_rdata),
        .out_a   (o1),
        .out_b   (o2)
    );

    assign ob_din.first  = k0_reg;
    assign ob_din.second = ks_rdata;

    pfc_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ob_load),
        .din      (ob_din),
        .busy     (ob_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CELLS_FULL)
        else $error("fill count beyond square size");

    a_j_used: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg[LETTER_J])
        else $error("letter J lost its used mark");

    a_text_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !full
         && (s_tuser == REQ_TEXT || s_tuser == REQ_END)) |=> state_reg == ST_IDLE)
        else $error("text request started a digram before the square was full");

    a_pair_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output buffer reloaded while a digram was in flight");

endmodule

// File: hw/rtl/pfc_ram.sv
// pfc_ram: generic single write port, single read port ram
// with registered read data, no dependencies
module pfc_ram #(
    parameter int WIDTH  = 5,
    parameter int DEPTH  = 25,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/pfc_cell_map.sv
// pfc_cell_map: registered digram rule, maps the two source cells
// to the two target cells; depends on pfc_pkg
module pfc_cell_map
    import pfc_pkg::*;
(
    input  logic              aclk,
    input  logic              load,
    input  logic              decrypt,
    input  logic [CELL_W-1:0] cell_a,
    input  logic [CELL_W-1:0] cell_b,
    output logic [CELL_W-1:0] out_a,
    output logic [CELL_W-1:0] out_b
);

    logic [RC_W-1:0]   r1, c1, r2, c2, x;
    logic [CELL_W-1:0] o1_next, o2_next;
    logic [CELL_W-1:0] o1_reg, o2_reg;

    always_comb begin
        x  = decrypt ? SHIFT_DEC : SHIFT_ENC;
        r1 = cell_row(cell_a);
        c1 = cell_col(cell_a);
        r2 = cell_row(cell_b);
        c2 = cell_col(cell_b);
        if (r1 == r2) begin
            o1_next = cell_at(r1, shift5(c1, x));
            o2_next = cell_at(r2, shift5(c2, x));
        end else if (c1 == c2) begin
            o1_next = cell_at(shift5(r1, x), c1);
            o2_next = cell_at(shift5(r2, x), c2);
        end else begin
            o1_next = cell_at(r1, c2);
            o2_next = cell_at(r2, c1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            o1_reg <= o1_next;
            o2_reg <= o2_next;
        end
    end

    assign out_a = o1_reg;
    assign out_b = o2_reg;

endmodule

// File: hw/rtl/pfc_out_buf.sv
// pfc_out_buf: holds one finished digram and sends its two letters
// on the result stream; depends on pfc_pkg
module pfc_out_buf
    import pfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  digram_t    din,
    output logic       busy,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [4:0] out_letter
    output logic       m_tlast    // pair_last
);

    digram_t data_reg;
    logic    busy_reg, busy_next;
    logic    second_reg, second_next;

    always_comb begin
        busy_next   = busy_reg;
        second_next = second_reg;
        if (load) begin
            busy_next   = 1'b1;
            second_next = 1'b0;
        end else if (busy_reg && m_tready) begin
            if (second_reg) begin
                busy_next = 1'b0;
            end else begin
                second_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= din;
        end
    end

    assign busy     = busy_reg;
    assign m_tvalid = busy_reg;
    assign m_tlast  = second_reg;
    assign m_tdata  = {3'b000, second_reg ? data_reg.second : data_reg.first};

endmodule

// File: bench/pfc_digram_checker.sv
`timescale 1ns / 1ps
// pfc_digram_checker: watches the request and cipher letter streams of the
// digram cipher, tracks the key square and pairing state, checks every letter
// depends on pfc_pkg
module pfc_digram_checker
    import pfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wen,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] letter
    input  logic [2:0] s_tuser,   // [2:0] req_type
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [4:0] out_letter
    input  logic       m_tlast,   // pair_last
    output int         fail_count,
    output int         outstanding,
    output int         letters_checked
);

    typedef struct {
        logic [LETTER_W-1:0] ltr;
        logic                last;
    } cipher_letter_t;

    cipher_letter_t      cipher_q[$];
    cipher_letter_t      want;
    logic [LETTER_W-1:0] square [CELLS];
    logic [CELL_W-1:0]   pos_of [LETTERS];
    logic [LETTERS-1:0]  placed;
    int                  filled;
    logic [LETTER_W-1:0] held_ltr;
    logic                held_on;
    logic                decrypt;
    int                  errs;
    int                  checked;

    function automatic void wipe_square();
        placed   = USED_RESET;
        filled   = 0;
        held_ltr = '0;
        held_on  = 1'b0;
    endfunction

    function automatic void place_letter(input logic [LETTER_W-1:0] l);
        if (l < LETTERS && filled < CELLS && !placed[l]) begin
            square[filled] = l;
            pos_of[l]      = CELL_W'(filled);
            placed[l]      = 1'b1;
            filled++;
        end
    endfunction

    function automatic logic [LETTER_W-1:0] pad_for(input logic [LETTER_W-1:0] l);
        return (l == LETTER_Z) ? LETTER_Y : LETTER_Z;
    endfunction

    function automatic void encipher_pair(input logic [LETTER_W-1:0] a,
                                          input logic [LETTER_W-1:0] b);
        int x, ia, ib, ra, ca, rb, cb, oa, ob;
        cipher_letter_t e;
        x  = decrypt ? int'(SHIFT_DEC) : int'(SHIFT_ENC);
        // j shares the cell of i
        ia = int'(pos_of[(a == LETTER_J) ? LETTER_I : a]);
        ib = int'(pos_of[(b == LETTER_J) ? LETTER_I : b]);
        ra = ia / SIDE;
        ca = ia % SIDE;
        rb = ib / SIDE;
        cb = ib % SIDE;
        if (ra == rb) begin
            oa = ra * SIDE + (ca + x) % SIDE;
            ob = rb * SIDE + (cb + x) % SIDE;
        end else if (ca == cb) begin
            oa = ((ra + x) % SIDE) * SIDE + ca;
            ob = ((rb + x) % SIDE) * SIDE + cb;
        end else begin
            oa = ra * SIDE + cb;
            ob = rb * SIDE + ca;
        end
        e.ltr  = square[oa];
        e.last = 1'b0;
        cipher_q.insert(cipher_q.size(), e);
        e.ltr  = square[ob];
        e.last = 1'b1;
        cipher_q.insert(cipher_q.size(), e);
    endfunction

    function automatic void take_request(input logic [2:0] kind,
                                         input logic [LETTER_W-1:0] l);
        case (kind)
            REQ_CLEAR: begin
                wipe_square();
            end
            REQ_KEY: begin
                place_letter(l);
            end
            REQ_FINISH: begin
                for (int t = 0; t < LETTERS; t++) place_letter(LETTER_W'(t));
            end
            REQ_TEXT: begin
                if (filled == CELLS && l < LETTERS) begin
                    if (!held_on) begin
                        held_ltr = l;
                        held_on  = 1'b1;
                    end else if (l == held_ltr) begin
                        // doubled letter: pad it, the new one stays held
                        encipher_pair(held_ltr, pad_for(held_ltr));
                    end else begin
                        held_on = 1'b0;
                        encipher_pair(held_ltr, l);
                    end
                end
            end
            REQ_END: begin
                if (filled == CELLS && held_on) begin
                    held_on = 1'b0;
                    encipher_pair(held_ltr, pad_for(held_ltr));
                end
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            wipe_square();
            decrypt = 1'b0;
            cipher_q.delete();
        end else begin
            if (cfg_wen) begin
                decrypt = cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                checked++;
                if (cipher_q.size() == 0) begin
                    errs++;
                    if (errs <= 10) begin
                        $display("letter %0d arrived with none expected: data %0d last %0b",
                                 checked, m_tdata, m_tlast);
                    end
                end else begin
                    want = cipher_q.pop_front();
                    if (m_tdata !== 8'(want.ltr) || m_tlast !== want.last) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("letter %0d: expected %0d last %0b, got %0d last %0b",
                                     checked, want.ltr, want.last, m_tdata, m_tlast);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                take_request(s_tuser, s_tdata[LETTER_W-1:0]);
            end
        end
        fail_count      <= errs;
        outstanding     <= cipher_q.size();
        letters_checked <= checked;
    end

endmodule

// File: bench/tb_playfair_digram_cipher.sv
`timescale 1ns / 1ps
// tb_playfair_digram_cipher: drives key, text and mode traffic into the digram
// cipher under several pacing phases and reports the verdict
// depends on pfc_pkg, playfair_digram_cipher and pfc_digram_checker
module tb_playfair_digram_cipher;
    import pfc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int PHASE_ITEMS    = 200;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wen;
    logic       cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [2:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int   fail_count;
    int   outstanding;
    int   letters_checked;
    int   send_idle;
    int   rx_stall;
    logic hold_rx;
    int   quiet;
    int   requests_sent;
    int   text_sent;

    playfair_digram_cipher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    pfc_digram_checker watch (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .letters_checked (letters_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= rx_stall);
        end
    end

    initial begin
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("no request or letter moved for %0d cycles", quiet);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [LETTER_W-1:0] pick_letter();
        if ($urandom_range(19) == 0) begin
            return LETTER_W'($urandom_range(31, LETTERS));
        end
        return LETTER_W'($urandom_range(LETTERS - 1));
    endfunction

    task automatic send_req(input logic [2:0] kind, input logic [LETTER_W-1:0] ltr);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= 8'(ltr);
        do begin
            @(posedge aclk);
        end while (!s_tready);
        requests_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic decrypt);
        cfg_wen   <= 1'b1;
        cfg_wdata <= decrypt;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic load_key(input bit whole_alphabet, input int n);
        int order [LETTERS];
        int j, tmp;
        send_req(REQ_CLEAR, LETTER_W'($urandom_range(31)));
        if (whole_alphabet) begin
            // square fills from the key alone, finish has nothing left to do
            for (int i = 0; i < LETTERS; i++) order[i] = i;
            for (int i = LETTERS - 1; i > 0; i--) begin
                j        = $urandom_range(i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < LETTERS; i++) send_req(REQ_KEY, LETTER_W'(order[i]));
            send_req(REQ_KEY, pick_letter());
        end else begin
            repeat (n) begin
                if ($urandom_range(19) == 0) begin
                    send_req(REQ_TEXT, pick_letter());
                end else begin
                    send_req(REQ_KEY, pick_letter());
                end
            end
        end
        send_req(REQ_FINISH, LETTER_W'($urandom_range(31)));
    endtask

    task automatic send_text(input int n);
        logic [LETTER_W-1:0] prev;
        logic [LETTER_W-1:0] l;
        prev = pick_letter();
        repeat (n) begin
            case ($urandom_range(9))
                0, 1, 2: l = prev;
                3: l = $urandom_range(1) ? LETTER_I : LETTER_J;
                default: l = pick_letter();
            endcase
            send_req(REQ_TEXT, l);
            prev = l;
            text_sent++;
        end
    endtask

    task automatic run_session();
        load_key($urandom_range(9) == 0, $urandom_range(12));
        repeat ($urandom_range(3, 1)) begin
            send_text($urandom_range(30, 1));
            if ($urandom_range(3) != 0) begin
                send_req(REQ_END, LETTER_W'($urandom_range(31)));
                text_sent++;
            end
            if ($urandom_range(9) == 0) begin
                send_req(3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO)),
                         pick_letter());
            end
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input logic decrypt,
                             input bit squeeze);
        int goal;
        drain();
        write_mode(decrypt);
        send_idle = idle;
        rx_stall  = stall;
        goal      = text_sent + PHASE_ITEMS;
        if (squeeze) begin
            // output side blocked while text keeps coming
            load_key(1'b0, 8);
            hold_rx <= 1'b1;
            send_text(40);
            send_req(REQ_END, LETTER_Z);
        end
        while (text_sent < goal) run_session();
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = REQ_CLEAR;
        hold_rx       = 1'b0;
        send_idle     = 0;
        rx_stall      = 0;
        requests_sent = 0;
        text_sent     = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_mode(1'b0);

        // text ahead of a finished square is dropped
        send_req(REQ_TEXT, LETTER_W'(0));
        send_req(REQ_END, LETTER_W'(0));
        send_req(REQ_KEY, LETTER_J);
        send_req(REQ_KEY, LETTER_W'(31));
        send_req(REQ_KEY, LETTER_W'(15));
        send_req(REQ_KEY, LETTER_W'(11));
        send_req(REQ_KEY, LETTER_W'(0));
        send_req(REQ_KEY, LETTER_Y);
        send_req(REQ_KEY, LETTER_W'(5));
        send_req(REQ_KEY, LETTER_I);
        send_req(REQ_KEY, LETTER_W'(17));
        send_req(REQ_KEY, LETTER_W'(0));
        send_req(REQ_FINISH, LETTER_W'(0));
        send_req(REQ_TEXT, LETTER_W'(31));
        send_req(REQ_TEXT, LETTER_W'(7));
        send_req(REQ_TEXT, LETTER_W'(7));
        send_req(REQ_TEXT, LETTER_W'(4));
        send_req(REQ_TEXT, LETTER_I);
        send_req(REQ_TEXT, LETTER_J);
        send_req(REQ_TEXT, LETTER_Z);
        send_req(REQ_TEXT, LETTER_Z);
        send_req(REQ_END, LETTER_W'(0));
        send_req(REQ_END, LETTER_W'(0));
        send_req(REQ_TEXT, LETTER_W'(0));
        send_req(REQ_END, LETTER_W'(0));
        send_req(REQ_SPARE_LO, LETTER_W'(31));
        send_req(REQ_SPARE_HI, LETTER_W'(21));
        send_req(REQ_FINISH, LETTER_W'(10));
        send_req(REQ_KEY, LETTER_W'(10));

        run_phase(0, 0, 1'b1, 1'b1);
        run_phase(68, 0, 1'b0, 1'b0);
        run_phase(0, 68, 1'b1, 1'b1);
        run_phase(35, 35, 1'b0, 1'b0);
        drain();

        $display("run: %0d requests, %0d of them text or end of text, in four pacing phases",
                 requests_sent, text_sent);
        $display("run: %0d cipher letters compared across encrypt and decrypt, %0d bad",
                 letters_checked, fail_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
